// ===== rtl/core/scc_pkg.sv =====
// Shared types, sizes and codes for the strongly connected components block.
`timescale 1ns / 1ps

package scc_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;

  localparam int NW  = $clog2(MAX_NODES);  // node index
  localparam int CW  = NW + 1;             // node count, stack depth
  localparam int EW  = $clog2(MAX_EDGES);  // edge index
  localparam int EPW = EW + 1;             // edge pointer with null code
  localparam int DW  = 7;                  // discovery / lowlink width
  localparam int FW  = NW + EPW + 2 * DW;  // call stack frame

  localparam logic [EPW-1:0] EDGE_NULL = EPW'(MAX_EDGES);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_WRITE,
    ST_ADD_LINK,
    ST_ROOT,
    ST_VISIT,
    ST_STEP,
    ST_EDGE,
    ST_LOW,
    ST_POP,
    ST_POP_DATA,
    ST_EMIT,
    ST_RET,
    ST_RET_DATA,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [NW-1:0]  node;
    logic [EPW-1:0] edge_ptr;
    logic [DW-1:0]  low;
    logic [DW-1:0]  disc;
  } frame_t;

endpackage

// ===== rtl/core/scc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/strongly_connected_components.sv =====
// Tarjan strongly connected components engine: edge store, search sequencer, output.
//
// Usage:
//   Slave stream s_*: one transaction per command. tuser carries the op
//   (add edge, run search, clear graph); tdata carries src_node and dst_node.
//   Master stream m_*: one transaction per node emitted by a run, grouped by
//   component; tuser flags the component end and edge overflow, tlast marks
//   the final node of the run.
//   cfg_*: writes node_count; write it only while the block is idle.
// Sequencing:
//   Add edge reads the source's tail, writes the edge memories, and then
//   links the new edge behind the old tail if the list has edges. Clear is
//   done in idle. A run visits, steps, returns and reloads a frame per node,
//   takes an edge step per edge plus a lowlink update when the target is on
//   the stack, pops and emits each popped node and checks each visited root,
//   paced by registered reads of edge, discovery, node and call stack memories.
//   Each result reaches m_* when the next node is popped, the final one at
//   the end of the run, so a result can trail its component by a subtree walk.
// Reset: empties all edge lists, clears the overflow flag, sets node_count
//   to 64. No clearing pass over memory is needed.
// Stall: results wait in a one-entry output register and one pending
//   register; the search holds while both are full.
`timescale 1ns / 1ps

module strongly_connected_components
  import scc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [5:0] src_node, [11:6] dst_node, [15:12] zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] node_id, [11:6] component_id, [15:12] zero
  output logic [1:0]  m_tuser,   // [0] component_end, [1] edge_overflow
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  state_t state, state_next;

  logic [CW-1:0]   node_count;
  logic [CW-1:0]   n_eff;
  logic [EPW-1:0]  edge_total;
  logic            overflow_flag;
  logic [MAX_NODES-1:0] head_valid;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] on_stack;

  logic [NW-1:0]   a_src;
  logic [NW-1:0]   a_dst;
  logic [EW-1:0]   a_edge;
  logic [EW-1:0]   a_link;

  logic [CW-1:0]   root;
  logic [NW-1:0]   visit_node;
  logic [NW-1:0]   cur_v;
  logic [EPW-1:0]  cur_e;
  logic [DW-1:0]   cur_low;
  logic [DW-1:0]   cur_disc;
  logic [CW-1:0]   call_depth;
  logic [CW-1:0]   stack_depth;
  logic [DW-1:0]   next_index;
  logic [NW-1:0]   comp;
  logic [NW-1:0]   pop_u;

  logic            pend_valid;
  logic [NW-1:0]   pend_node;
  logic [NW-1:0]   pend_comp;
  logic            pend_end;

  logic            s_fire;
  logic            out_free;
  logic            can_emit;
  logic            emit;
  logic            pop_end;
  op_t             in_op;

  // Memory ports
  logic            head_we, tail_we, tgt_we, nxt_we, disc_we, ns_we, cs_we;
  logic [NW-1:0]   head_raddr, disc_raddr, ns_raddr, cs_raddr, cs_waddr, ns_waddr;
  logic [EW-1:0]   head_rdata, tail_rdata, nxt_waddr;
  logic [NW-1:0]   tgt_rdata;
  logic [EPW-1:0]  nxt_wdata, nxt_rdata;
  logic [DW-1:0]   disc_rdata;
  logic [NW-1:0]   ns_rdata;
  frame_t          cs_wdata, cs_rdata;

  assign in_op     = op_t'(s_tuser);
  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Saturate the node count to 1..MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      n_eff = CW'(1);
    end else if (node_count > CW'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign can_emit = !pend_valid || out_free;
  assign pop_end  = (pop_u == cur_v);
  assign emit     = (state == ST_EMIT) && can_emit;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          if (in_op == OP_ADD && !edge_total[EW]) begin
            state_next = ST_ADD_WRITE;
          end else if (in_op == OP_RUN) begin
            state_next = ST_ROOT;
          end
        end
      end
      ST_ADD_WRITE: state_next = head_valid[a_src] ? ST_ADD_LINK : ST_IDLE;
      ST_ADD_LINK:  state_next = ST_IDLE;
      ST_ROOT: begin
        if (root == n_eff) begin
          state_next = ST_FLUSH;
        end else if (!visited[root[NW-1:0]]) begin
          state_next = ST_VISIT;
        end
      end
      ST_VISIT: state_next = ST_STEP;
      ST_STEP: begin
        if (!cur_e[EW]) begin
          state_next = ST_EDGE;
        end else if (cur_low == cur_disc) begin
          state_next = ST_POP;
        end else begin
          state_next = ST_RET;
        end
      end
      ST_EDGE: begin
        if ({1'b0, tgt_rdata} >= n_eff) begin
          state_next = ST_STEP;
        end else if (!visited[tgt_rdata]) begin
          state_next = ST_VISIT;
        end else if (on_stack[tgt_rdata]) begin
          state_next = ST_LOW;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_LOW:      state_next = ST_STEP;
      ST_POP:      state_next = ST_POP_DATA;
      ST_POP_DATA: state_next = ST_EMIT;
      ST_EMIT: begin
        if (can_emit) begin
          state_next = pop_end ? ST_RET : ST_POP;
        end
      end
      ST_RET:      state_next = (call_depth == '0) ? ST_ROOT : ST_RET_DATA;
      ST_RET_DATA: state_next = ST_STEP;
      ST_FLUSH:    state_next = out_free ? ST_IDLE : ST_FLUSH;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    head_we   = (state == ST_ADD_WRITE) && !head_valid[a_src];
    tail_we   = (state == ST_ADD_WRITE);
    tgt_we    = (state == ST_ADD_WRITE);
    nxt_we    = (state == ST_ADD_WRITE) || (state == ST_ADD_LINK);
    nxt_waddr = (state == ST_ADD_LINK) ? a_link : edge_total[EW-1:0];
    nxt_wdata = (state == ST_ADD_LINK) ? {1'b0, a_edge} : EDGE_NULL;
    disc_we   = (state == ST_VISIT);
    ns_we     = (state == ST_VISIT);
    ns_waddr  = stack_depth[NW-1:0];
    cs_we     = (state == ST_VISIT) && (call_depth != '0);
    cs_waddr  = NW'(call_depth - CW'(1));
    cs_wdata  = '{node: cur_v, edge_ptr: cur_e, low: cur_low, disc: cur_disc};
    head_raddr = (state == ST_ROOT) ? root[NW-1:0] : tgt_rdata;
    disc_raddr = tgt_rdata;
    ns_raddr   = NW'(stack_depth - CW'(1));
    cs_raddr   = NW'(call_depth - CW'(1));
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      node_count    <= CW'(MAX_NODES);
      edge_total    <= '0;
      overflow_flag <= 1'b0;
      head_valid    <= '0;
      visited       <= '0;
      on_stack      <= '0;
      root          <= '0;
      call_depth    <= '0;
      stack_depth   <= '0;
      next_index    <= DW'(1);
      comp          <= '0;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      // Load the output register, or drop it once taken
      if ((emit && pend_valid) || (state == ST_FLUSH && out_free)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            case (in_op)
              OP_ADD: begin
                if (edge_total[EW]) begin
                  overflow_flag <= 1'b1;
                end
              end
              OP_RUN: begin
                visited     <= '0;
                on_stack    <= '0;
                root        <= '0;
                call_depth  <= '0;
                stack_depth <= '0;
                next_index  <= DW'(1);
                comp        <= '0;
              end
              OP_CLEAR: begin
                head_valid    <= '0;
                edge_total    <= '0;
                overflow_flag <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_ADD_WRITE: begin
          head_valid[a_src] <= 1'b1;
          edge_total        <= edge_total + EPW'(1);
        end
        ST_ROOT: begin
          if (root != n_eff && visited[root[NW-1:0]]) begin
            root <= root + CW'(1);
          end
        end
        ST_VISIT: begin
          visited[visit_node]  <= 1'b1;
          on_stack[visit_node] <= 1'b1;
          next_index  <= next_index + DW'(1);
          stack_depth <= stack_depth + CW'(1);
          call_depth  <= call_depth + CW'(1);
        end
        ST_STEP: begin
          if (cur_e[EW]) begin
            call_depth <= call_depth - CW'(1);
          end
        end
        ST_POP: stack_depth <= stack_depth - CW'(1);
        ST_EMIT: begin
          if (can_emit) begin
            on_stack[pop_u] <= 1'b0;
            if (pop_end) begin
              comp <= comp + NW'(1);
            end
          end
        end
        ST_RET: begin
          if (call_depth == '0) begin
            root <= root + CW'(1);
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
      // Keep the new result pending
      if (emit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Search and output datapath
  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_src <= s_tdata[NW-1:0];
      a_dst <= s_tdata[2*NW-1:NW];
    end
    if (state == ST_ADD_WRITE) begin
      a_edge <= edge_total[EW-1:0];
      a_link <= tail_rdata;
    end
    if (state == ST_ROOT) begin
      visit_node <= root[NW-1:0];
    end
    if (state == ST_EDGE) begin
      visit_node <= tgt_rdata;
      cur_e      <= nxt_rdata;
    end
    if (state == ST_VISIT) begin
      cur_v    <= visit_node;
      cur_e    <= head_valid[visit_node] ? {1'b0, head_rdata} : EDGE_NULL;
      cur_low  <= next_index;
      cur_disc <= next_index;
    end
    if (state == ST_LOW && disc_rdata < cur_low) begin
      cur_low <= disc_rdata;
    end
    if (state == ST_POP_DATA) begin
      pop_u <= ns_rdata;
    end
    if (state == ST_RET_DATA) begin
      cur_v    <= cs_rdata.node;
      cur_e    <= cs_rdata.edge_ptr;
      cur_disc <= cs_rdata.disc;
      cur_low  <= (cur_low < cs_rdata.low) ? cur_low : cs_rdata.low;
    end
    if (emit) begin
      pend_node <= pop_u;
      pend_comp <= comp;
      pend_end  <= pop_end;
      if (pend_valid) begin
        m_tdata <= {4'b0, pend_comp, pend_node};
        m_tuser <= {overflow_flag, pend_end};
        m_tlast <= 1'b0;
      end
    end
    if (state == ST_FLUSH && out_free) begin
      m_tdata <= {4'b0, pend_comp, pend_node};
      m_tuser <= {overflow_flag, pend_end};
      m_tlast <= 1'b1;
    end
  end

  scc_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_head (
    .clk(clk), .we(head_we), .waddr(a_src), .wdata(edge_total[EW-1:0]),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  scc_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_tail (
    .clk(clk), .we(tail_we), .waddr(a_src), .wdata(edge_total[EW-1:0]),
    .raddr(s_tdata[NW-1:0]), .rdata(tail_rdata)
  );

  scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_target (
    .clk(clk), .we(tgt_we), .waddr(edge_total[EW-1:0]), .wdata(a_dst),
    .raddr(cur_e[EW-1:0]), .rdata(tgt_rdata)
  );

  scc_ram #(.WIDTH(EPW), .DEPTH(MAX_EDGES)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(cur_e[EW-1:0]), .rdata(nxt_rdata)
  );

  scc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_disc (
    .clk(clk), .we(disc_we), .waddr(visit_node), .wdata(next_index),
    .raddr(disc_raddr), .rdata(disc_rdata)
  );

  scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_stack (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(visit_node),
    .raddr(ns_raddr), .rdata(ns_rdata)
  );

  scc_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_call_stack (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .raddr(cs_raddr), .rdata(cs_rdata)
  );

  // No result may be held back while a new command is taken
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid)
    else $error("pending result left when returning to idle");

  // Call depth never passes node stack depth, which never passes MAX_NODES
  a_depths: assert property (@(posedge clk) disable iff (rst)
    (call_depth <= stack_depth) && (stack_depth <= CW'(MAX_NODES)))
    else $error("call stack deeper than node stack");

  // A popped node must still be marked on the stack
  a_pop_on_stack: assert property (@(posedge clk) disable iff (rst)
    emit |-> on_stack[pop_u])
    else $error("emitted node not on the stack");

  // Edge count never passes capacity
  a_edge_cap: assert property (@(posedge clk) disable iff (rst)
    edge_total <= EPW'(MAX_EDGES))
    else $error("edge count beyond capacity");

endmodule
